// File: rtl/xfc_pkg.sv
// ----------------------------------------------------------------------------
// xfc_pkg
// shared types and constants of the xor frame checker
// ----------------------------------------------------------------------------
package xfc_pkg;

    localparam int HEADER_BYTES = 8;
    localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
    localparam int COUNT_W      = 17;
    localparam int LEN_W        = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [7:0] SYNC_BYTE = 8'hAA;
    localparam logic [7:0] USER_TAG  = 8'h99;
    localparam logic [7:0] BOOT_TAG  = 8'h90;

    // index of the checksum byte is the declared length plus this offset
    localparam logic [COUNT_W-1:0] BOOT_LAST_OFS = 17'd4;
    localparam logic [COUNT_W-1:0] USER_LAST_OFS = 17'd8;

    typedef enum logic [1:0] {
        ERR_OK         = 2'd0,
        ERR_PREFIX     = 2'd1,
        ERR_INCOMPLETE = 2'd2,
        ERR_CHECKSUM   = 2'd3
    } err_code_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       buffer_end;
    } in_item_t;

    typedef struct packed {
        logic             frame_ok;
        err_code_t        error_code;
        logic             is_boot_frame;
        logic [7:0]       module_id;
        logic [7:0]       command;
        logic [7:0]       subcommand;
        logic [7:0]       sender_flag;
        logic [LEN_W-1:0] declared_length;
    } result_t;

endpackage

// File: rtl/xfc_in_stage.sv
// ----------------------------------------------------------------------------
// xfc_in_stage
// input register holding one received byte until the checker takes it
// ----------------------------------------------------------------------------
module xfc_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  xfc_pkg::in_item_t s_item,
    input  logic              take,
    output logic              item_valid,
    output xfc_pkg::in_item_t item
);

    logic              valid_reg;
    logic              valid_next;
    xfc_pkg::in_item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign valid_next = (valid_reg && !take) || (s_valid && s_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: rtl/xfc_core.sv
// ----------------------------------------------------------------------------
// xfc_core
// per-byte frame state: header capture, length decode, running xor, verdict
// ----------------------------------------------------------------------------
module xfc_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  xfc_pkg::in_item_t item,
    output xfc_pkg::result_t  result
);

    logic [xfc_pkg::COUNT_W-1:0] byte_count_reg;
    logic [xfc_pkg::COUNT_W-1:0] byte_count_next;
    logic [7:0]                  running_xor_reg;
    logic [7:0]                  running_xor_next;
    logic                        frame_known_reg;
    logic                        frame_known_next;
    logic [xfc_pkg::COUNT_W-1:0] frame_last_reg;
    logic [xfc_pkg::COUNT_W-1:0] frame_last_next;
    logic [7:0]                  header_reg [xfc_pkg::HEADER_BYTES];
    logic [7:0]                  header_next [xfc_pkg::HEADER_BYTES];
    xfc_pkg::err_code_t          verdict_reg;
    xfc_pkg::err_code_t          verdict_next;
    logic                        verdict_done_reg;
    logic                        verdict_done_next;

    logic                        is_boot;
    logic                        is_user;
    logic [xfc_pkg::LEN_W-1:0]   boot_len;
    logic [xfc_pkg::LEN_W-1:0]   user_len;
    xfc_pkg::err_code_t          code;

    always_comb begin
        header_next = header_reg;
        if (byte_count_reg < xfc_pkg::COUNT_W'(xfc_pkg::HEADER_BYTES)) begin
            header_next[byte_count_reg[xfc_pkg::HDR_IDX_W-1:0]] = item.rx_byte;
        end
    end

    assign is_boot  = (header_next[0] == xfc_pkg::SYNC_BYTE)
                   && (header_next[1] == xfc_pkg::BOOT_TAG);
    assign is_user  = (header_next[0] == xfc_pkg::SYNC_BYTE)
                   && (header_next[1] == xfc_pkg::USER_TAG);
    assign boot_len = {header_next[3], header_next[2]};
    assign user_len = {header_next[7], header_next[6]};

    always_comb begin
        verdict_next      = verdict_reg;
        verdict_done_next = verdict_done_reg;
        frame_known_next  = frame_known_reg;
        frame_last_next   = frame_last_reg;
        running_xor_next  = running_xor_reg;

        // prefix check once both prefix bytes (sync and tag) are in
        if (!verdict_done_reg && byte_count_reg == 17'd1 && !is_boot && !is_user) begin
            verdict_next      = xfc_pkg::ERR_PREFIX;
            verdict_done_next = 1'b1;
        end

        if (!verdict_done_next) begin
            if (!frame_known_reg) begin
                if (byte_count_reg == 17'd3 && is_boot) begin
                    frame_known_next = 1'b1;
                    frame_last_next  = xfc_pkg::COUNT_W'(boot_len) + xfc_pkg::BOOT_LAST_OFS;
                end else if (byte_count_reg == 17'd7 && is_user) begin
                    frame_known_next = 1'b1;
                    frame_last_next  = xfc_pkg::COUNT_W'(user_len) + xfc_pkg::USER_LAST_OFS;
                end
            end
            if (frame_known_next && byte_count_reg == frame_last_next) begin
                verdict_next      = (running_xor_reg == item.rx_byte) ? xfc_pkg::ERR_OK
                                                                      : xfc_pkg::ERR_CHECKSUM;
                verdict_done_next = 1'b1;
            end else begin
                running_xor_next = running_xor_reg ^ item.rx_byte;
            end
        end

        byte_count_next = (byte_count_reg == xfc_pkg::COUNT_MAX) ? byte_count_reg
                                                                 : byte_count_reg + 1'b1;
    end

    // verdict for a buffer ending on this byte
    always_comb begin
        if (verdict_done_next) begin
            code = verdict_next;
        end else if (byte_count_reg == '0) begin
            code = xfc_pkg::ERR_PREFIX;
        end else begin
            code = xfc_pkg::ERR_INCOMPLETE;
        end

        result            = '0;
        result.error_code = code;
        result.frame_ok   = (code == xfc_pkg::ERR_OK);
        if (code != xfc_pkg::ERR_PREFIX) begin
            result.is_boot_frame   = is_boot;
            result.module_id       = header_next[2];
            result.command         = is_boot ? header_next[4] : header_next[3];
            result.subcommand      = is_boot ? 8'h00 : header_next[4];
            result.sender_flag     = header_next[5];
            result.declared_length = is_boot ? boot_len : user_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && item.buffer_end)) begin
            byte_count_reg   <= '0;
            running_xor_reg  <= '0;
            frame_known_reg  <= 1'b0;
            frame_last_reg   <= '0;
            verdict_reg      <= xfc_pkg::ERR_OK;
            verdict_done_reg <= 1'b0;
            for (int k = 0; k < xfc_pkg::HEADER_BYTES; k++) begin
                header_reg[k] <= '0;
            end
        end else if (step) begin
            byte_count_reg   <= byte_count_next;
            running_xor_reg  <= running_xor_next;
            frame_known_reg  <= frame_known_next;
            frame_last_reg   <= frame_last_next;
            verdict_reg      <= verdict_next;
            verdict_done_reg <= verdict_done_next;
            header_reg       <= header_next;
        end
    end

    // state is cleared after the buffer's last byte
    a_clear_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.buffer_end |=> byte_count_reg == '0 && !verdict_done_reg
                                    && !frame_known_reg)
        else $error("frame state not cleared after buffer end");

    // length is only known once the length field has arrived
    a_known_after_len: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_known_reg |-> byte_count_reg >= 17'd4)
        else $error("frame length known too early");

    // a decided verdict needs at least the two prefix bytes
    a_done_after_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        verdict_done_reg |-> byte_count_reg >= 17'd2)
        else $error("verdict decided before prefix");

endmodule

// File: rtl/xfc_out_stage.sv
// ----------------------------------------------------------------------------
// xfc_out_stage
// result register holding one verdict until the receiver takes it
// ----------------------------------------------------------------------------
module xfc_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  xfc_pkg::result_t result,
    output logic             free,
    output logic             m_valid,
    input  logic             m_ready,
    output xfc_pkg::result_t m_result
);

    logic             valid_reg;
    xfc_pkg::result_t result_reg;

    assign free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (free && load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    // a result is never overwritten while waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !m_ready |-> !(free && load))
        else $error("pending result overwritten");

    // ok flag agrees with the error code
    a_ok_matches_code: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> result_reg.frame_ok == (result_reg.error_code == xfc_pkg::ERR_OK))
        else $error("frame_ok disagrees with error_code");

endmodule

// File: rtl/xor_frame_checker.sv
// ----------------------------------------------------------------------------
// xor_frame_checker
// checks received buffers against the xor-checksum command frame format
// ----------------------------------------------------------------------------
// usage:
//   s_ channel: one buffer byte per transfer, s_buffer_end high on the
//   buffer's last byte. m_ channel: one verdict per buffer with the decoded
//   header fields (zeros on a bad prefix).
//   a byte is registered on transfer into the input register and processed
//   by the frame state logic when it is taken; a buffer end is taken only
//   once the result register is free, and its verdict lands in the result
//   register at the edge that takes it, and m_valid rises with it.
//   throughput is one byte per cycle unless a buffer end waits on the
//   result register; byte count, running xor and header update together.
//   while a verdict waits on m_ready, bytes that do not end a buffer keep
//   flowing; a buffer end waits in the input register until the result
//   register frees, and s_ready drops behind it.
//   reset (aresetn low, synchronous) empties both registers and clears the
//   frame state; each verdict also clears it for the next buffer.
// ----------------------------------------------------------------------------
module xor_frame_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_buffer_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_frame_ok,
    output logic [1:0]  m_error_code,
    output logic        m_is_boot_frame,
    output logic [7:0]  m_module_id,
    output logic [7:0]  m_command,
    output logic [7:0]  m_subcommand,
    output logic [7:0]  m_sender_flag,
    output logic [15:0] m_declared_length
);

    xfc_pkg::in_item_t s_item;
    xfc_pkg::in_item_t item;
    logic              item_valid;
    logic              take;
    logic              out_free;
    xfc_pkg::result_t  result;
    xfc_pkg::result_t  m_result;

    assign s_item.rx_byte    = s_rx_byte;
    assign s_item.buffer_end = s_buffer_end;

    assign take = item_valid && (!item.buffer_end || out_free);

    xfc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    xfc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (take),
        .item    (item),
        .result  (result)
    );

    xfc_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (take && item.buffer_end),
        .result   (result),
        .free     (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_frame_ok        = m_result.frame_ok;
    assign m_error_code      = m_result.error_code;
    assign m_is_boot_frame   = m_result.is_boot_frame;
    assign m_module_id       = m_result.module_id;
    assign m_command         = m_result.command;
    assign m_subcommand      = m_result.subcommand;
    assign m_sender_flag     = m_result.sender_flag;
    assign m_declared_length = m_result.declared_length;

endmodule

// File: tb/frame_verdict_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_verdict_checker
// tracks byte transfers with its own frame state, queues the verdict due at
// each buffer end and compares every verdict transfer field by field
// ----------------------------------------------------------------------------
module frame_verdict_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_buffer_end,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_frame_ok,
    input  logic [1:0]  m_error_code,
    input  logic        m_is_boot_frame,
    input  logic [7:0]  m_module_id,
    input  logic [7:0]  m_command,
    input  logic [7:0]  m_subcommand,
    input  logic [7:0]  m_sender_flag,
    input  logic [15:0] m_declared_length,
    output int          fail_count,
    output int          pending_count
);

    logic [xfc_pkg::COUNT_W-1:0] seen_cnt;
    logic [7:0]                  xor_acc;
    logic [xfc_pkg::COUNT_W-1:0] frame_len;
    logic [7:0]                  hdr [xfc_pkg::HEADER_BYTES];
    xfc_pkg::err_code_t          held_code;
    logic                        code_set;
    xfc_pkg::result_t            verdict_q [$];

    task automatic clear_frame_state();
        seen_cnt  = '0;
        xor_acc   = '0;
        frame_len = '0;
        hdr       = '{default: '0};
        held_code = xfc_pkg::ERR_OK;
        code_set  = 1'b0;
    endtask

    task automatic report_mismatch(input string msg);
        if (fail_count < 200) begin
            $display("%0t mismatch: %s", $time, msg);
        end
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    task automatic track_frame_byte(input logic [7:0] b, input logic last);
        logic [xfc_pkg::COUNT_W-1:0] idx;
        logic                        boot;
        logic                        user;
        xfc_pkg::err_code_t          code;
        xfc_pkg::result_t            r;
        idx = seen_cnt;
        if (idx < xfc_pkg::HEADER_BYTES) begin
            hdr[idx[xfc_pkg::HDR_IDX_W-1:0]] = b;
        end
        boot = (hdr[0] == xfc_pkg::SYNC_BYTE) && (hdr[1] == xfc_pkg::BOOT_TAG);
        user = (hdr[0] == xfc_pkg::SYNC_BYTE) && (hdr[1] == xfc_pkg::USER_TAG);

        if (!code_set && idx == 1 && !boot && !user) begin
            held_code = xfc_pkg::ERR_PREFIX;
            code_set  = 1'b1;
        end

        if (!code_set) begin
            if (frame_len == 0) begin
                if (idx == 3 && boot) begin
                    frame_len = {1'b0, hdr[3], hdr[2]} + 17'd5;
                end else if (idx == 7 && user) begin
                    frame_len = {1'b0, hdr[7], hdr[6]} + 17'd9;
                end
            end
            if (frame_len != 0 && idx == frame_len - 17'd1) begin
                held_code = (xor_acc == b) ? xfc_pkg::ERR_OK : xfc_pkg::ERR_CHECKSUM;
                code_set  = 1'b1;
            end else begin
                xor_acc ^= b;
            end
        end

        if (seen_cnt != xfc_pkg::COUNT_MAX) begin
            seen_cnt++;
        end

        if (last) begin
            if (code_set) begin
                code = held_code;
            end else if (seen_cnt < 2) begin
                code = xfc_pkg::ERR_PREFIX;
            end else begin
                code = xfc_pkg::ERR_INCOMPLETE;
            end
            r            = '0;
            r.error_code = code;
            r.frame_ok   = (code == xfc_pkg::ERR_OK);
            if (code != xfc_pkg::ERR_PREFIX) begin
                r.is_boot_frame   = boot;
                r.module_id       = hdr[2];
                r.command         = boot ? hdr[4] : hdr[3];
                r.subcommand      = boot ? 8'h00 : hdr[4];
                r.sender_flag     = hdr[5];
                r.declared_length = boot ? {hdr[3], hdr[2]} : {hdr[7], hdr[6]};
            end
            verdict_q.push_back(r);
            clear_frame_state();
        end
    endtask

    task automatic compare_verdict();
        xfc_pkg::result_t want;
        if (verdict_q.size() == 0) begin
            report_mismatch("verdict transfer with none expected");
        end else begin
            want = verdict_q.pop_front();
            check_field("frame_ok", 16'(m_frame_ok), 16'(want.frame_ok));
            check_field("error_code", 16'(m_error_code), 16'(want.error_code));
            check_field("is_boot_frame", 16'(m_is_boot_frame), 16'(want.is_boot_frame));
            check_field("module_id", 16'(m_module_id), 16'(want.module_id));
            check_field("command", 16'(m_command), 16'(want.command));
            check_field("subcommand", 16'(m_subcommand), 16'(want.subcommand));
            check_field("sender_flag", 16'(m_sender_flag), 16'(want.sender_flag));
            check_field("declared_length", m_declared_length, want.declared_length);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_frame_state();
            verdict_q.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                compare_verdict();
            end
            if (s_valid && s_ready) begin
                track_frame_byte(s_rx_byte, s_buffer_end);
            end
        end
        pending_count <= verdict_q.size();
    end

endmodule

// File: tb/tb_xor_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_xor_frame_checker
// directed and random byte buffers into the xor frame checker with random
// idling on both channels; gives the verdict of the run
// ----------------------------------------------------------------------------
module tb_xor_frame_checker;

    localparam int CYCLE_LIMIT       = 600000;
    localparam int RANDOM_BYTES      = 650;
    localparam int MIN_RANDOM_FRAMES = 40;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic [7:0]  s_rx_byte    = 8'h00;
    logic        s_buffer_end = 1'b0;
    logic        m_ready      = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic        m_frame_ok;
    logic [1:0]  m_error_code;
    logic        m_is_boot_frame;
    logic [7:0]  m_module_id;
    logic [7:0]  m_command;
    logic [7:0]  m_subcommand;
    logic [7:0]  m_sender_flag;
    logic [15:0] m_declared_length;
    int          fail_count;
    int          pending_count;

    logic [7:0] frame_q [$];
    logic       steady      = 1'b0;
    int         ready_hold  = 0;
    int         cycle_cnt   = 0;
    int         bytes_sent  = 0;
    int         frames_sent = 0;

    xor_frame_checker dut (.*);

    frame_verdict_checker u_check (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // result side stalls
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
            m_ready <= 1'b0;
        end else if (!steady && $urandom_range(0, 2) == 0) begin
            ready_hold = gap_len();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_frame();
        int gap;
        int k;
        for (k = 0; k < frame_q.size(); k++) begin
            s_valid      <= 1'b1;
            s_rx_byte    <= frame_q[k];
            s_buffer_end <= (k == frame_q.size() - 1);
            do @(posedge aclk); while (!s_ready);
            bytes_sent++;
            gap = steady ? 0 : gap_len();
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        frames_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
    endtask

    task automatic start_frame(input logic boot, input logic [15:0] len);
        frame_q.delete();
        frame_q.push_back(xfc_pkg::SYNC_BYTE);
        frame_q.push_back(boot ? xfc_pkg::BOOT_TAG : xfc_pkg::USER_TAG);
        if (!boot) begin
            repeat (4) frame_q.push_back(8'($urandom_range(0, 255)));
        end
        frame_q.push_back(len[7:0]);
        frame_q.push_back(len[15:8]);
    endtask

    task automatic add_payload(input int n);
        repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic close_frame(input logic corrupt);
        logic [7:0] x;
        x = 8'h00;
        foreach (frame_q[k]) begin
            x ^= frame_q[k];
        end
        if (corrupt) begin
            x ^= 8'($urandom_range(1, 255));
        end
        frame_q.push_back(x);
    endtask

    task automatic trim(input int n);
        while (frame_q.size() > n) begin
            void'(frame_q.pop_back());
        end
    endtask

    task automatic run_directed();
        // short and wrong prefixes
        frame_q.delete();
        frame_q.push_back(xfc_pkg::SYNC_BYTE);
        send_frame();
        frame_q.delete();
        frame_q.push_back(8'h00);
        send_frame();
        frame_q.delete();
        frame_q.push_back(8'hFF);
        frame_q.push_back(xfc_pkg::USER_TAG);
        send_frame();
        frame_q.delete();
        frame_q.push_back(xfc_pkg::SYNC_BYTE);
        frame_q.push_back(8'h98);
        add_payload(8);
        send_frame();
        // user frames
        start_frame(1'b0, 16'd0);
        trim(2);
        send_frame();
        start_frame(1'b0, 16'd0);
        for (int k = 2; k < 6; k++) frame_q[k] = 8'hFF;
        close_frame(1'b0);
        send_frame();
        start_frame(1'b0, 16'd0);
        for (int k = 2; k < 6; k++) frame_q[k] = 8'h00;
        close_frame(1'b0);
        send_frame();
        start_frame(1'b0, 16'd3);
        add_payload(3);
        close_frame(1'b1);
        send_frame();
        start_frame(1'b0, 16'd2);
        trim(5);
        send_frame();
        start_frame(1'b0, 16'd2);
        add_payload(2);
        send_frame();
        start_frame(1'b0, 16'hFFFF);
        add_payload(3);
        send_frame();
        // bootloader frames
        start_frame(1'b1, 16'd0);
        close_frame(1'b0);
        send_frame();
        start_frame(1'b1, 16'd0);
        close_frame(1'b0);
        add_payload(3);
        send_frame();
        start_frame(1'b1, 16'd1);
        add_payload(1);
        close_frame(1'b1);
        send_frame();
        start_frame(1'b1, 16'hFFFF);
        add_payload(4);
        send_frame();
        start_frame(1'b1, 16'd0);
        trim(3);
        send_frame();
        wait_drained();
    endtask

    task automatic make_random_frame();
        int   r;
        int   len;
        logic boot;
        r    = $urandom_range(0, 99);
        boot = 1'($urandom_range(0, 1));
        if (r < 70) begin
            len = $urandom_range(0, 99);
            if (len < 90) begin
                len = $urandom_range(0, 8);
            end else if (len < 98) begin
                len = $urandom_range(9, 40);
            end else begin
                len = $urandom_range(200, 300);
            end
            start_frame(boot, 16'(len));
            add_payload(len);
            close_frame($urandom_range(0, 9) == 0);
            r = $urandom_range(0, 99);
            if (r < 15) begin
                trim($urandom_range(1, frame_q.size() - 1));
            end else if (r < 35) begin
                add_payload($urandom_range(1, 4));
            end
        end else if (r < 85) begin
            start_frame(boot, 16'($urandom_range(0, 65535)));
            add_payload($urandom_range(0, 6));
        end else begin
            frame_q.delete();
            add_payload($urandom_range(1, 10));
            if ($urandom_range(0, 1) == 1) begin
                frame_q[0] = xfc_pkg::SYNC_BYTE;
            end
        end
    endtask

    initial begin
        int byte_base;
        int frame_base;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();

        byte_base  = bytes_sent;
        frame_base = frames_sent;
        while (bytes_sent - byte_base < RANDOM_BYTES ||
               frames_sent - frame_base < MIN_RANDOM_FRAMES) begin
            if ($urandom_range(0, 14) == 0) begin
                steady = !steady;
            end
            make_random_frame();
            send_frame();
            if ($urandom_range(0, 24) == 0) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
